[hdl/hsvm_pkg.sv]
package hsvm_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned HUE_W   = 9;
    localparam int unsigned SAT_W   = 7;
    localparam int unsigned VAL_W   = 15;
    localparam int unsigned HNUM_W  = 17;
    localparam int unsigned SNUM_W  = 15;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    localparam logic [HUE_W-1:0] HUE_LOW_RST  = 9'd0;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST = 9'd360;
    localparam logic [SAT_W-1:0] SAT_LOW_RST  = 7'd0;
    localparam logic [SAT_W-1:0] SAT_HIGH_RST = 7'd100;
    localparam logic [VAL_W-1:0] VAL_LOW_RST  = 15'd0;
    localparam logic [VAL_W-1:0] VAL_HIGH_RST = 15'd25500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW  = 3'd0,
        REG_HUE_HIGH = 3'd1,
        REG_SAT_LOW  = 3'd2,
        REG_SAT_HIGH = 3'd3,
        REG_VAL_LOW  = 3'd4,
        REG_VAL_HIGH = 3'd5
    } cfg_index_t;

    // hue = hnum/hden, sat = snum/sden, value = vnum
    typedef struct packed {
        logic [HNUM_W-1:0] hnum;
        logic [CHAN_W-1:0] hden;
        logic [SNUM_W-1:0] snum;
        logic [CHAN_W-1:0] sden;
        logic [VAL_W-1:0]  vnum;
        logic              eof;
    } hsv_frac_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_low;
        logic [HUE_W-1:0] hue_high;
        logic [SAT_W-1:0] sat_low;
        logic [SAT_W-1:0] sat_high;
        logic [VAL_W-1:0] val_low;
        logic [VAL_W-1:0] val_high;
    } bounds_t;

endpackage

[hdl/hsvm_color_convert.sv]
module hsvm_color_convert
    import hsvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    input  logic [CHAN_W-1:0] r,
    input  logic [CHAN_W-1:0] g,
    input  logic [CHAN_W-1:0] b,
    input  logic              eof,
    output logic              frac_valid,
    output hsv_frac_t         frac
);

    logic [CHAN_W-1:0] mx, mn, d;
    logic signed [18:0] rs, gs, bs, ds, hn;
    hsv_frac_t frac_next, frac_reg;
    logic valid_reg;

    always_comb
    begin
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d  = mx - mn;
        rs = $signed({11'b0, r});
        gs = $signed({11'b0, g});
        bs = $signed({11'b0, b});
        ds = $signed({11'b0, d});
        // ties resolve red first, then green
        priority if (mx == r)
        begin
            hn = 19'sd60 * (gs - bs);
            if (g < b) hn = hn + 19'sd360 * ds;
        end
        else if (mx == g)
        begin
            hn = 19'sd60 * (bs - rs) + 19'sd120 * ds;
        end
        else
        begin
            hn = 19'sd60 * (rs - gs) + 19'sd240 * ds;
        end

        frac_next.eof  = eof;
        frac_next.vnum = {7'b0, mx} * 15'd100;
        if (d == '0)
        begin
            frac_next.hnum = '0;
            frac_next.hden = 8'd1;
            frac_next.snum = '0;
            frac_next.sden = 8'd1;
        end
        else
        begin
            frac_next.hnum = hn[HNUM_W-1:0];
            frac_next.hden = d;
            frac_next.snum = {7'b0, d} * 15'd100;
            frac_next.sden = mx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
    end

    assign frac_valid = valid_reg;
    assign frac       = frac_reg;

endmodule

[hdl/hsvm_range_check.sv]
module hsvm_range_check
    import hsvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      frac_valid,
    input  hsv_frac_t frac,
    input  bounds_t   bounds,
    output logic      res_valid,
    output logic      res_in_range,
    output logic      res_last
);

    logic [HNUM_W-1:0] hlo_x, hhi_x;
    logic [SNUM_W-1:0] slo_x, shi_x;
    logic hue_ok, sat_ok, val_ok;
    logic valid_reg, in_range_reg, last_reg;
    logic in_range_next;

    // cross-multiplied bounds: lo*den <= num <= hi*den
    always_comb
    begin
        hlo_x  = {8'b0, bounds.hue_low}  * {9'b0, frac.hden};
        hhi_x  = {8'b0, bounds.hue_high} * {9'b0, frac.hden};
        slo_x  = {8'b0, bounds.sat_low}  * {7'b0, frac.sden};
        shi_x  = {8'b0, bounds.sat_high} * {7'b0, frac.sden};
        hue_ok = (frac.hnum >= hlo_x) && (frac.hnum <= hhi_x);
        sat_ok = (frac.snum >= slo_x) && (frac.snum <= shi_x);
        val_ok = (frac.vnum >= bounds.val_low) && (frac.vnum <= bounds.val_high);
        in_range_next = hue_ok && sat_ok && val_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= frac_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
        last_reg     <= frac.eof;
    end

    assign res_valid    = valid_reg;
    assign res_in_range = in_range_reg;
    assign res_last     = last_reg;

endmodule

[hdl/hsv_range_pixel_mask_unit.sv]
// HSV range mask. One RGB888 pixel per request, one request per clock; busy
// is always low. Each request gives exactly one result, registered in turn in
// the input register, color conversion register and range compare register,
// marked by result_valid for one cycle; results cannot be stalled.
// Hue (degrees), saturation (percent) and value (max*100) are tested against
// inclusive bounds as exact fractions; gray pixels have hue 0 and saturation 0.
// Bound registers are written through the cfg port, which is always ready;
// write them only while no pixel is in flight.
module hsv_range_pixel_mask_unit
    import hsvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic                  end_of_frame,
    output logic                  result_valid,
    output logic                  in_range,
    output logic                  frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bounds_t   bounds_reg;
    logic      pix_valid_reg;
    logic [CHAN_W-1:0] r_reg, g_reg, b_reg;
    logic      eof_reg;
    logic      frac_valid;
    hsv_frac_t frac;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.hue_low  <= HUE_LOW_RST;
            bounds_reg.hue_high <= HUE_HIGH_RST;
            bounds_reg.sat_low  <= SAT_LOW_RST;
            bounds_reg.sat_high <= SAT_HIGH_RST;
            bounds_reg.val_low  <= VAL_LOW_RST;
            bounds_reg.val_high <= VAL_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_HUE_LOW:  bounds_reg.hue_low  <= cfg_data[HUE_W-1:0];
                REG_HUE_HIGH: bounds_reg.hue_high <= cfg_data[HUE_W-1:0];
                REG_SAT_LOW:  bounds_reg.sat_low  <= cfg_data[SAT_W-1:0];
                REG_SAT_HIGH: bounds_reg.sat_high <= cfg_data[SAT_W-1:0];
                REG_VAL_LOW:  bounds_reg.val_low  <= cfg_data[VAL_W-1:0];
                REG_VAL_HIGH: bounds_reg.val_high <= cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= red;
        g_reg   <= green;
        b_reg   <= blue;
        eof_reg <= end_of_frame;
    end

    hsvm_color_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid_reg),
        .r          (r_reg),
        .g          (g_reg),
        .b          (b_reg),
        .eof        (eof_reg),
        .frac_valid (frac_valid),
        .frac       (frac)
    );

    hsvm_range_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .frac_valid   (frac_valid),
        .frac         (frac),
        .bounds       (bounds_reg),
        .res_valid    (result_valid),
        .res_in_range (in_range),
        .res_last     (frame_last)
    );

    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 result_valid)
        else $error("request did not produce a result after three cycles");

    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 3))
        else $error("result without a matching request");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 (frame_last == $past(end_of_frame, 3)))
        else $error("frame_last does not match the request's end_of_frame");

    a_black_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        frac_valid && frac.vnum == '0 |-> frac.snum == '0 && frac.hnum == '0)
        else $error("black pixel has nonzero hue or saturation");

endmodule
